FILE: rtl/mvm_pkg.sv
// ============================================================================
// mvm_pkg - shared types and constants for the matrix-vector multiplier
// Sizes, command and register codes, and the item passed from the front end
// to the multiply-accumulate back end.
// ============================================================================
package mvm_pkg;

    // Store and counter sizing
    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = 12;
    localparam int LEN_W       = 13;

    // Operand and accumulator widths
    localparam int OPD_W  = 16;
    localparam int PROD_W = 2 * OPD_W;
    localparam int ACC_W  = 48;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // Configuration register indexes
    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_ROW_COUNT  = 1'b1;

    // One weight request with its operand and row bookkeeping
    typedef struct packed {
        logic signed [OPD_W-1:0] weight;
        logic signed [OPD_W-1:0] vec;
        logic                    end_of_row;
        logic [ROW_W-1:0]        row;
        logic                    last;
    } mvm_item_t;

endpackage

FILE: rtl/matrix_vector_multiply.sv
// One weight request per cycle sustained unless the queue backs up; loads are also taken one per cycle.
// A row sum reaches m_tvalid through the front stage with its store read, the
// queue, the product register and the result register.
// A load is visible to a weight accepted in the following cycle.
// Synchronous active-low reset clears counters, accumulator, queue and valids
// and sets both length registers to 4096; the vector store is not cleared.
// ============================================================================
// matrix_vector_multiply - streaming matrix-vector product
// Front end sequences columns and rows and reads the vector store; a short
// queue feeds the multiply-accumulate back end that emits row sums.
// ============================================================================
module matrix_vector_multiply (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [mvm_pkg::LEN_W-1:0]        cfg_wdata,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [11:0] vec_index, [27:12] vec_value, [43:28] weight_value, [47:44] zero
    input  logic [mvm_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] cmd
    input  logic                             s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [47:0] row_sum, [59:48] row_number, [63:60] zero
    output logic [mvm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);

    logic                             f_valid;
    logic                             f_ready;
    mvm_pkg::mvm_item_t               f_item;
    logic                             q_valid;
    logic                             q_ready;
    mvm_pkg::mvm_item_t               q_item;
    logic signed [mvm_pkg::ACC_W-1:0] b_sum;
    logic [mvm_pkg::ROW_W-1:0]        b_row;

    mvm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_index  (s_tdata[11:0]),
        .in_vec    (s_tdata[27:12]),
        .in_weight (s_tdata[43:28]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    mvm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    mvm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (b_sum),
        .out_row   (b_row),
        .out_last  (m_tlast)
    );

    // Pack the result
    assign m_tdata = {4'b0000, b_row, b_sum};

endmodule

FILE: rtl/mvm_front.sv
// ============================================================================
// mvm_front - request intake, vector store and row/column sequencing
// Loads write the vector store; weights read the element at the running
// column and leave a registered item with row-end and last-row flags.
// ============================================================================
module mvm_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [mvm_pkg::LEN_W-1:0]        cfg_wdata,
    // request input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_cmd,
    input  logic [mvm_pkg::COL_W-1:0]        in_index,
    input  logic signed [mvm_pkg::OPD_W-1:0] in_vec,
    input  logic signed [mvm_pkg::OPD_W-1:0] in_weight,
    // item output
    output logic                             out_valid,
    input  logic                             out_ready,
    output mvm_pkg::mvm_item_t               out_item
);

    logic [mvm_pkg::LEN_W-1:0] row_length_reg;
    logic [mvm_pkg::LEN_W-1:0] row_count_reg;
    logic [mvm_pkg::LEN_W-1:0] len_eff;
    logic [mvm_pkg::LEN_W-1:0] cnt_eff;

    logic [mvm_pkg::COL_W-1:0] col_reg;
    logic [mvm_pkg::COL_W-1:0] col_next;
    logic [mvm_pkg::ROW_W-1:0] row_reg;
    logic [mvm_pkg::ROW_W-1:0] row_next;

    logic                      st_valid_reg;
    logic signed [mvm_pkg::OPD_W-1:0] st_weight_reg;
    logic signed [mvm_pkg::OPD_W-1:0] st_vec_reg;
    logic                      st_eor_reg;
    logic [mvm_pkg::ROW_W-1:0] st_row_reg;
    logic                      st_last_reg;

    logic                      in_acc;
    logic                      is_weight;
    logic                      stage_adv;
    logic                      eor;
    logic                      last;

    logic signed [mvm_pkg::OPD_W-1:0] vec_mem [mvm_pkg::MAX_COLUMNS];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= mvm_pkg::LEN_W'(mvm_pkg::MAX_COLUMNS);
            row_count_reg  <= mvm_pkg::LEN_W'(mvm_pkg::MAX_ROWS);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mvm_pkg::REG_ROW_LENGTH: row_length_reg <= cfg_wdata;
                mvm_pkg::REG_ROW_COUNT:  row_count_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Zero acts as one, oversize acts as the maximum
    always_comb begin
        if (row_length_reg == '0)
            len_eff = mvm_pkg::LEN_W'(1);
        else if (row_length_reg > mvm_pkg::LEN_W'(mvm_pkg::MAX_COLUMNS))
            len_eff = mvm_pkg::LEN_W'(mvm_pkg::MAX_COLUMNS);
        else
            len_eff = row_length_reg;

        if (row_count_reg == '0)
            cnt_eff = mvm_pkg::LEN_W'(1);
        else if (row_count_reg > mvm_pkg::LEN_W'(mvm_pkg::MAX_ROWS))
            cnt_eff = mvm_pkg::LEN_W'(mvm_pkg::MAX_ROWS);
        else
            cnt_eff = row_count_reg;
    end

    // Handshake: the stage moves when empty or when the queue takes it
    assign stage_adv = !st_valid_reg || out_ready;
    assign in_ready  = stage_adv;
    assign in_acc    = in_valid && in_ready;
    assign is_weight = (in_cmd == mvm_pkg::CMD_WEIGHT);

    // Row and product end tests
    assign eor  = ({1'b0, col_reg} + mvm_pkg::LEN_W'(1)) >= len_eff;
    assign last = ({1'b0, row_reg} + mvm_pkg::LEN_W'(1)) >= cnt_eff;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc && is_weight) begin
            if (eor) begin
                col_next = '0;
                row_next = last ? '0 : row_reg + mvm_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + mvm_pkg::COL_W'(1);
            end
        end
    end

    // Counters and stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (stage_adv)
                st_valid_reg <= in_acc && is_weight;
        end
    end

    // Vector store: write on load, registered read on weight
    always_ff @(posedge aclk) begin
        if (in_acc && !is_weight && (32'(in_index) < mvm_pkg::MAX_COLUMNS))
            vec_mem[in_index] <= in_vec;
        if (in_acc && is_weight)
            st_vec_reg <= vec_mem[col_reg];
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (in_acc && is_weight) begin
            st_weight_reg <= in_weight;
            st_eor_reg    <= eor;
            st_row_reg    <= row_reg;
            st_last_reg   <= last;
        end
    end

    assign out_valid           = st_valid_reg;
    assign out_item.weight     = st_weight_reg;
    assign out_item.vec        = st_vec_reg;
    assign out_item.end_of_row = st_eor_reg;
    assign out_item.row        = st_row_reg;
    assign out_item.last       = st_last_reg;

endmodule

FILE: rtl/mvm_queue.sv
// ============================================================================
// mvm_queue - short FIFO between front end and back end
// Lets intake and multiply-accumulate stall independently.
// ============================================================================
module mvm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  mvm_pkg::mvm_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mvm_pkg::mvm_item_t pop_item
);

    mvm_pkg::mvm_item_t entries [mvm_pkg::Q_DEPTH];

    logic [mvm_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [mvm_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [mvm_pkg::Q_CNT_W-1:0] count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != mvm_pkg::Q_CNT_W'(mvm_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entries[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + mvm_pkg::Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + mvm_pkg::Q_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + mvm_pkg::Q_CNT_W'(1);
            else if (!do_push && do_pop)
                count_reg <= count_reg - mvm_pkg::Q_CNT_W'(1);
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push)
            entries[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/mvm_back.sv
// ============================================================================
// mvm_back - multiply-accumulate back end
// Registered 16x16 product, 48-bit accumulator, and a result register that
// holds a row sum until it is taken.
// ============================================================================
module mvm_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mvm_pkg::mvm_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [mvm_pkg::ACC_W-1:0] out_sum,
    output logic [mvm_pkg::ROW_W-1:0]        out_row,
    output logic                             out_last
);

    logic                              p_valid_reg;
    logic signed [mvm_pkg::PROD_W-1:0] p_prod_reg;
    logic                              p_eor_reg;
    logic [mvm_pkg::ROW_W-1:0]         p_row_reg;
    logic                              p_last_reg;

    logic signed [mvm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  acc_next;

    logic                              o_valid_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  o_sum_reg;
    logic [mvm_pkg::ROW_W-1:0]         o_row_reg;
    logic                              o_last_reg;

    logic                              out_free;
    logic                              p_adv;
    logic                              in_acc;

    // A row end needs a free result register; other products just add
    assign out_free = !o_valid_reg || out_ready;
    assign p_adv    = p_valid_reg && (!p_eor_reg || out_free);
    assign in_ready = !p_valid_reg || p_adv;
    assign in_acc   = in_valid && in_ready;
    assign acc_next = acc_reg + mvm_pkg::ACC_W'(p_prod_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            acc_reg     <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            if (in_ready)
                p_valid_reg <= in_valid;
            if (p_adv)
                acc_reg <= p_eor_reg ? '0 : acc_next;
            if (p_adv && p_eor_reg)
                o_valid_reg <= 1'b1;
            else if (out_ready)
                o_valid_reg <= 1'b0;
        end
    end

    // Product stage
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            p_prod_reg <= in_item.weight * in_item.vec;
            p_eor_reg  <= in_item.end_of_row;
            p_row_reg  <= in_item.row;
            p_last_reg <= in_item.last;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (p_adv && p_eor_reg) begin
            o_sum_reg  <= acc_next;
            o_row_reg  <= p_row_reg;
            o_last_reg <= p_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_sum   = o_sum_reg;
    assign out_row   = o_row_reg;
    assign out_last  = o_last_reg;

endmodule

FILE: rtl/mvm_checker.sv
// ============================================================================
// mvm_checker - port-level checks for the matrix-vector multiplier
// Watches the result stream for hold behavior, reset, and row numbering.
// ============================================================================
module mvm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mvm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    logic [mvm_pkg::ROW_W-1:0] exp_row_reg;

    // Expected row number: counts up per result, back to zero after last row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_row_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            exp_row_reg <= m_tlast ? '0 : exp_row_reg + mvm_pkg::ROW_W'(1);
        end
    end

    // Stalled result keeps its request
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Rows come out in order, restarting after the last row
    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[59:48] == exp_row_reg)
        else $error("row number out of sequence");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: dv/tb_matrix_vector_multiply.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_matrix_vector_multiply - self-checking bench for the streaming GEMV block
// Loads vector elements and streams row-major weights under random bursts and
// result back-pressure. A local row-sum predictor models the block. Every
// emitted row sum, row number and last flag is checked in order against it.
// ============================================================================
module tb_matrix_vector_multiply;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 8;      // idle cycles waited after the last row sum is back

    typedef struct packed {
        logic [mvm_pkg::ACC_W-1:0] sum;
        logic [mvm_pkg::ROW_W-1:0] rnum;
        logic                      last;
    } row_result_t;

    typedef enum logic {STEP_REG, STEP_ITEM} step_kind_t;

    // one row of the directed table: a register write or a request
    typedef struct packed {
        step_kind_t                kind;
        logic                      reg_idx;
        logic [mvm_pkg::LEN_W-1:0] reg_val;
        logic                      cmd;
        logic [11:0]               idx;
        logic [15:0]               vval;
        logic [15:0]               wval;
        logic                      chk;
        logic [mvm_pkg::ACC_W-1:0] want_sum;
        logic [mvm_pkg::ROW_W-1:0] want_row;
        logic                      want_last;
    } step_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic                            cfg_index = 1'b0;
    logic [mvm_pkg::LEN_W-1:0]       cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [mvm_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [mvm_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    // predictor state
    logic [15:0]               vec_mem [mvm_pkg::MAX_COLUMNS];
    bit                        vec_written [mvm_pkg::MAX_COLUMNS];
    logic [mvm_pkg::ACC_W-1:0] acc_sum = '0;
    int unsigned               col_pos = 0;
    int unsigned               row_pos = 0;
    logic [mvm_pkg::LEN_W-1:0] len_reg = 13'd4096;
    logic [mvm_pkg::LEN_W-1:0] cnt_reg = 13'd4096;

    row_result_t pending_rows [$];
    int          error_count = 0;
    int          item_count  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    rx_mode_t    rx_mode     = RX_OPEN;
    int          rx_hold     = 0;

    // directed table: extremes first, then multi-column rows and mid-row changes
    step_t dir_steps [25] = '{
        '{STEP_REG,  mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_LOAD,   12'd0,
          16'h0000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_REG,  mvm_pkg::REG_ROW_COUNT,  13'd0, mvm_pkg::CMD_LOAD,   12'd0,
          16'h0000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_LOAD,   12'd0,
          16'h7FFF, 16'hFFFF, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'hFFF,
          16'hFFFF, 16'h7FFF, 1'b1, 48'h0000_3FFF_0001, 12'd0, 1'b1},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h8000, 1'b1, 48'hFFFF_C000_8000, 12'd0, 1'b1},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_LOAD,   12'd0,
          16'h8000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h8000, 1'b1, 48'h0000_4000_0000, 12'd0, 1'b1},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_LOAD,   12'hFFF,
          16'h0000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_LOAD,   12'd1,
          16'h0100, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_LOAD,   12'd2,
          16'hFFFF, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_REG,  mvm_pkg::REG_ROW_LENGTH, 13'd3, mvm_pkg::CMD_LOAD,   12'd0,
          16'h0000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_REG,  mvm_pkg::REG_ROW_COUNT,  13'd2, mvm_pkg::CMD_LOAD,   12'd0,
          16'h0000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0100, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0200, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0001, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h7FFF, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h8000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'hFFFF, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0100, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0100, 1'b0, 48'h0, 12'd0, 1'b0},
        // shrink the row while sitting on column 2: next weight closes the row
        '{STEP_REG,  mvm_pkg::REG_ROW_LENGTH, 13'd2, mvm_pkg::CMD_LOAD,   12'd0,
          16'h0000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0100, 1'b0, 48'h0, 12'd0, 1'b0},
        // shrink the product while on row 1: that row becomes the last
        '{STEP_REG,  mvm_pkg::REG_ROW_COUNT,  13'd1, mvm_pkg::CMD_LOAD,   12'd0,
          16'h0000, 16'h0000, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0100, 1'b0, 48'h0, 12'd0, 1'b0},
        '{STEP_ITEM, mvm_pkg::REG_ROW_LENGTH, 13'd0, mvm_pkg::CMD_WEIGHT, 12'd0,
          16'h0000, 16'h0100, 1'b0, 48'h0, 12'd0, 1'b0}
    };

    matrix_vector_multiply i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // register value 0 acts as 1, anything past the maximum as the maximum
    function automatic int unsigned eff_size(input logic [mvm_pkg::LEN_W-1:0] v,
                                             input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    // row-sum predictor: returns 1 when the request closes a row
    function automatic bit gemv_predict(input logic cmd, input logic [11:0] idx,
                                        input logic [15:0] vv, input logic [15:0] wv,
                                        output row_result_t res);
        int unsigned        len_eff;
        int unsigned        cnt_eff;
        logic signed [31:0] prod;
        res = '0;
        if (cmd == mvm_pkg::CMD_LOAD) begin
            vec_mem[idx]     = vv;
            vec_written[idx] = 1'b1;
            return 1'b0;
        end
        len_eff = eff_size(len_reg, mvm_pkg::MAX_COLUMNS);
        cnt_eff = eff_size(cnt_reg, mvm_pkg::MAX_ROWS);
        prod    = $signed(wv) * $signed(vec_mem[col_pos[mvm_pkg::COL_W-1:0]]);
        acc_sum = acc_sum + {{16{prod[31]}}, prod};
        if (col_pos + 1 < len_eff) begin
            col_pos++;
            return 1'b0;
        end
        res.sum  = acc_sum;
        res.rnum = row_pos[mvm_pkg::ROW_W-1:0];
        res.last = (row_pos + 1 >= cnt_eff);
        acc_sum  = '0;
        col_pos  = 0;
        row_pos  = res.last ? 0 : row_pos + 1;
        return 1'b1;
    endfunction

    // present one request, wait for acceptance, then maybe open a gap
    task automatic send_request(input logic cmd, input logic [11:0] idx,
                                input logic [15:0] vv, input logic [15:0] wv,
                                input bit use_typed, input row_result_t typed_res);
        row_result_t res;
        bit          got;
        int          gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, wv, vv, idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        got = gemv_predict(cmd, idx, vv, wv, res);
        if (got)
            pending_rows.push_back(use_typed ? typed_res : res);
        item_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drain: no request in flight, every row sum back, block settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [mvm_pkg::LEN_W-1:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == mvm_pkg::REG_ROW_LENGTH)
            len_reg = val;
        else
            cnt_reg = val;
    endtask

    task automatic send_weight(input logic [15:0] wv);
        send_request(mvm_pkg::CMD_WEIGHT, 12'($urandom), 16'($urandom), wv, 1'b0, '0);
    endtask

    // load every store entry below len that was never written
    task automatic fill_vector(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            if (!vec_written[i[11:0]])
                send_request(mvm_pkg::CMD_LOAD, i[11:0], 16'($urandom), 16'($urandom),
                             1'b0, '0);
    endtask

    // small random phases: short rows, few rows, often ending mid-row
    task automatic run_small_phases(input int upto);
        logic [mvm_pkg::LEN_W-1:0] len_val;
        logic [mvm_pkg::LEN_W-1:0] cnt_val;
        int unsigned               len_eff;
        int unsigned               n_weights;
        logic [15:0]               wv;
        while (item_count < upto) begin
            case ($urandom_range(0, 9))
                0:       len_val = 13'd0;
                1:       len_val = 13'd1;
                default: len_val = 13'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       cnt_val = 13'd0;
                1:       cnt_val = 13'd1;
                default: cnt_val = 13'($urandom_range(2, 6));
            endcase
            write_reg(mvm_pkg::REG_ROW_LENGTH, len_val);
            write_reg(mvm_pkg::REG_ROW_COUNT, cnt_val);
            len_eff = eff_size(len_val, mvm_pkg::MAX_COLUMNS);
            fill_vector(len_eff);
            n_weights = $urandom_range(1, eff_size(cnt_val, mvm_pkg::MAX_ROWS) + 3) * len_eff;
            if ($urandom_range(0, 2) == 0)
                n_weights -= $urandom_range(0, len_eff - 1);
            for (int unsigned k = 0; k < n_weights; k++) begin
                if ($urandom_range(0, 7) == 0)
                    send_request(mvm_pkg::CMD_LOAD, 12'($urandom_range(0, 4095)),
                                 16'($urandom), 16'($urandom), 1'b0, '0);
                case ($urandom_range(0, 9))
                    0:       wv = 16'h7FFF;
                    1:       wv = 16'h8000;
                    default: wv = 16'($urandom);
                endcase
                send_weight(wv);
            end
        end
    endtask

    // result side back-pressure: open, random, or periodic stretches
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_hold <= $urandom_range(50, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
            default:   m_tready <= (cycle_count[1:0] == 2'd0);
        endcase
    end

    // result checker
    always @(posedge aclk) begin
        row_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rows.size() == 0) begin
                error_count++;
                $display("%0t: unexpected row sum, expected none, actual sum %h row %0d last %b",
                         $time, m_tdata[47:0], m_tdata[59:48], m_tlast);
            end else begin
                want = pending_rows.pop_front();
                if (m_tdata[47:0] !== want.sum) begin
                    error_count++;
                    $display("%0t: row_sum expected %h actual %h", $time, want.sum,
                             m_tdata[47:0]);
                end
                if (m_tdata[59:48] !== want.rnum) begin
                    error_count++;
                    $display("%0t: row_number expected %0d actual %0d", $time, want.rnum,
                             m_tdata[59:48]);
                end
                if (m_tlast !== want.last) begin
                    error_count++;
                    $display("%0t: last_row expected %b actual %b", $time, want.last,
                             m_tlast);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        row_result_t typed;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_REG) begin
                write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
            end else begin
                typed = '{dir_steps[i].want_sum, dir_steps[i].want_row, dir_steps[i].want_last};
                send_request(dir_steps[i].cmd, dir_steps[i].idx, dir_steps[i].vval,
                             dir_steps[i].wval, dir_steps[i].chk, typed);
            end
        end

        run_small_phases(item_count + 250);

        // out-of-range registers act as the maximum, left mid-row
        write_reg(mvm_pkg::REG_ROW_LENGTH, 13'd8191);
        write_reg(mvm_pkg::REG_ROW_COUNT, 13'd8191);
        fill_vector(32);
        for (int k = 0; k < 5; k++)
            send_weight(16'($urandom));

        // zero length acts as one: the next weight closes the open row
        write_reg(mvm_pkg::REG_ROW_LENGTH, 13'd0);
        for (int k = 0; k < 120; k++)
            send_weight(16'($urandom));

        run_small_phases(item_count + 180);

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mvm_pkg.sv
rtl/mvm_front.sv
rtl/mvm_queue.sv
rtl/mvm_back.sv
rtl/matrix_vector_multiply.sv
rtl/mvm_checker.sv
dv/tb_matrix_vector_multiply.sv
